// ----- sv/ufp_pkg.sv -----
// Types, codes and helper functions shared by the form parser files.
package ufp_pkg;

    localparam logic [7:0] C_AMP = 8'h26;  // '&'
    localparam logic [7:0] C_EQ  = 8'h3D;  // '='
    localparam logic [7:0] C_PCT = 8'h25;  // '%'

    localparam int unsigned N_RES = 4;

    typedef enum logic [1:0] {
        ROLE_NAME     = 2'd0,
        ROLE_VALUE    = 2'd1,
        ROLE_PAIR_END = 2'd2
    } t_role;

    typedef enum logic [1:0] {
        SEG_NAME  = 2'd0,
        SEG_VALUE = 2'd1,
        SEG_DROP  = 2'd2
    } t_seg;

    typedef enum logic [1:0] {
        ESC_NONE  = 2'd0,
        ESC_PCT   = 2'd1,
        ESC_DIGIT = 2'd2
    } t_esc;

    typedef struct packed {
        t_seg       seg;
        t_esc       esc;
        logic [7:0] held;
    } t_state;

    typedef struct packed {
        logic [7:0] out_byte;
        t_role      role;
        logic       has_value;
    } t_result;

    typedef struct packed {
        t_result [N_RES-1:0] ent;
        logic [2:0]          cnt;
    } t_burst;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    localparam t_state C_STATE_RST = '{seg: SEG_NAME, esc: ESC_NONE, held: 8'h00};

    function automatic t_hex hex_digit(input logic [7:0] c);
        t_hex h;
        h = '{ok: 1'b0, val: 4'h0};
        if (c >= 8'h30 && c <= 8'h39) begin
            h = '{ok: 1'b1, val: 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h = '{ok: 1'b1, val: 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h = '{ok: 1'b1, val: 4'(c - 8'h57)};
        end
        return h;
    endfunction

    function automatic t_burst burst_push(input t_burst b, input t_result r);
        t_burst o;
        o = b;
        if (b.cnt < 3'(N_RES)) begin
            o.ent[b.cnt[1:0]] = r;
            o.cnt = b.cnt + 3'd1;
        end
        return o;
    endfunction

endpackage

// ----- sv/ufp_if.sv -----
// Request channel interfaces for the form parser: raw byte in, tagged result out.
interface ufp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       body_last;

    modport source (output valid, output in_byte, output body_last, input ready);
    modport sink   (input valid, input in_byte, input body_last, output ready);
endinterface

interface ufp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] role;
    logic       has_value;
    logic       run_last;

    modport source (output valid, output out_byte, output role, output has_value,
                    output run_last, input ready);
    modport sink   (input valid, input out_byte, input role, input has_value,
                    input run_last, output ready);
endinterface

// ----- sv/urlencoded_form_parser_top.sv -----
// Top level of the URL-encoded form parser: input register, decoder, result buffer.
//
//   channel | direction | payload                                  | handshake
//   i_in    | in        | in_byte[7:0], body_last                   | valid/ready
//   o_out   | out       | out_byte[7:0], role[1:0], has_value, run_last | valid/ready
//
// A request lands in the input register; its results (0 to 4) are decoded against
// the parser state and loaded all at once into the result buffer. Results leave
// one per cycle while the output is ready, so single-result bytes stream at one
// per cycle. A result reaches the output via the input register, then the buffer.
// Reset is synchronous, active low: name segment, no escape held.
// A stalled output holds the buffer; one further request waits in the input register.
module urlencoded_form_parser_top
    import ufp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    ufp_in_if.sink     i_in,
    ufp_out_if.source  o_out
);

    t_state              r_state;
    t_state              n_state;
    t_burst              n_burst;
    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_in_last;
    t_result [N_RES-1:0] r_ent;
    logic [2:0]          r_cnt;
    logic [1:0]          r_idx;

    logic in_fire;
    logic out_fire;
    logic load;

    ufp_decode u_decode (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_state (n_state),
        .o_burst (n_burst)
    );

    assign out_fire = o_out.valid && o_out.ready;
    assign load     = r_in_valid && ((r_cnt == 3'd0) || ((r_cnt == 3'd1) && o_out.ready));
    assign in_fire  = i_in.valid && i_in.ready;

    assign i_in.ready      = !r_in_valid || load;
    assign o_out.valid     = (r_cnt != 3'd0);
    assign o_out.out_byte  = r_ent[r_idx].out_byte;
    assign o_out.role      = r_ent[r_idx].role;
    assign o_out.has_value = r_ent[r_idx].has_value;
    assign o_out.run_last  = (r_cnt == 3'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= C_STATE_RST;
            r_in_valid <= 1'b0;
            r_cnt      <= 3'd0;
            r_idx      <= 2'd0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (load) begin
                r_in_valid <= 1'b0;
            end
            if (load) begin
                r_state <= n_state;
                r_cnt   <= n_burst.cnt;
                r_idx   <= 2'd0;
            end else if (out_fire) begin
                r_cnt <= r_cnt - 3'd1;
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte <= i_in.in_byte;
            r_in_last <= i_in.body_last;
        end
        if (load) begin
            r_ent <= n_burst.ent;
        end
    end

endmodule

// ----- sv/ufp_decode.sv -----
// Decoder for one raw byte: next parser state and the list of results it causes.
module ufp_decode
    import ufp_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_state     o_state,
    output t_burst     o_burst
);

    always_comb begin
        t_state  s;
        t_burst  bl;
        t_hex    hx;
        t_hex    hh;
        t_role   drole;
        logic    dropping;

        s   = i_state;
        bl  = '0;
        hx  = hex_digit(i_byte);
        hh  = hex_digit(s.held);
        dropping = (s.seg != SEG_NAME) && (s.seg != SEG_VALUE);
        drole    = (s.seg == SEG_NAME) ? ROLE_NAME : ROLE_VALUE;

        if (dropping) begin
            s.esc = ESC_NONE;
            if (i_byte == C_AMP) begin
                bl    = burst_push(bl, '{out_byte: 8'h00, role: ROLE_PAIR_END, has_value: 1'b1});
                s.seg = SEG_NAME;
            end
        end else if (i_byte == C_AMP || i_byte == C_EQ) begin
            // unfinished escape goes out literally in the current segment
            if (s.esc == ESC_PCT || s.esc == ESC_DIGIT) begin
                bl = burst_push(bl, '{out_byte: C_PCT, role: drole, has_value: 1'b0});
            end
            if (s.esc == ESC_DIGIT) begin
                bl = burst_push(bl, '{out_byte: s.held, role: drole, has_value: 1'b0});
            end
            s.esc = ESC_NONE;
            if (i_byte == C_AMP) begin
                bl = burst_push(bl, '{out_byte: 8'h00, role: ROLE_PAIR_END,
                                      has_value: (s.seg != SEG_NAME)});
                s.seg = SEG_NAME;
            end else begin
                s.seg = (s.seg == SEG_NAME) ? SEG_VALUE : SEG_DROP;
            end
        end else begin
            case (s.esc)
                ESC_PCT: begin
                    if (hx.ok) begin
                        s.held = i_byte;
                        s.esc  = ESC_DIGIT;
                    end else begin
                        bl    = burst_push(bl, '{out_byte: C_PCT, role: drole, has_value: 1'b0});
                        s.esc = ESC_NONE;
                    end
                end
                ESC_DIGIT: begin
                    if (hx.ok) begin
                        bl = burst_push(bl, '{out_byte: {(hh.ok ? hh.val : 4'h0), hx.val},
                                              role: drole, has_value: 1'b0});
                    end else begin
                        bl = burst_push(bl, '{out_byte: C_PCT, role: drole, has_value: 1'b0});
                        bl = burst_push(bl, '{out_byte: s.held, role: drole, has_value: 1'b0});
                    end
                    s.esc = ESC_NONE;
                end
                default: begin
                    s.esc = ESC_NONE;
                end
            endcase
            // failing byte, or a byte outside an escape, handled on its own
            if (!(i_state.esc == ESC_PCT && hx.ok) && !(i_state.esc == ESC_DIGIT && hx.ok)) begin
                if (i_byte == C_PCT) begin
                    s.esc = ESC_PCT;
                end else begin
                    bl = burst_push(bl, '{out_byte: i_byte, role: drole, has_value: 1'b0});
                end
            end
        end

        if (i_last) begin
            drole = (s.seg == SEG_NAME) ? ROLE_NAME : ROLE_VALUE;
            if (s.seg == SEG_NAME || s.seg == SEG_VALUE) begin
                if (s.esc == ESC_PCT || s.esc == ESC_DIGIT) begin
                    bl = burst_push(bl, '{out_byte: C_PCT, role: drole, has_value: 1'b0});
                end
                if (s.esc == ESC_DIGIT) begin
                    bl = burst_push(bl, '{out_byte: s.held, role: drole, has_value: 1'b0});
                end
            end
            bl = burst_push(bl, '{out_byte: 8'h00, role: ROLE_PAIR_END,
                                  has_value: (s.seg != SEG_NAME)});
            s.seg  = SEG_NAME;
            s.esc  = ESC_NONE;
            s.held = 8'h00;
        end

        o_state = s;
        o_burst = bl;
    end

endmodule

// ----- sv/ufp_checker.sv -----
// Port-level checker for the form parser, bound to the top level.
module ufp_checker
    import ufp_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic [1:0] i_out_role,
    input logic       i_out_has_value,
    input logic       i_out_run_last
);

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_byte) && $stable(i_out_role)
            && $stable(i_out_has_value) && $stable(i_out_run_last))
        else $error("result changed while stalled");

    a_pair_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_role == ROLE_PAIR_END) |-> (i_out_byte == 8'h00))
        else $error("pair end carries a non-zero byte");

    a_data_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_role != ROLE_PAIR_END) |-> !i_out_has_value)
        else $error("byte result flags has_value");

    a_role_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_role == ROLE_NAME) || (i_out_role == ROLE_VALUE)
                        || (i_out_role == ROLE_PAIR_END))
        else $error("unused role code on output");

endmodule

bind urlencoded_form_parser_top ufp_checker u_ufp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_byte      (o_out.out_byte),
    .i_out_role      (o_out.role),
    .i_out_has_value (o_out.has_value),
    .i_out_run_last  (o_out.run_last)
);

// ----- dv/urlencoded_form_parser_checker.sv -----
// Result checker for the form parser: predicts tagged results per request and compares them.
`timescale 1ns / 100ps

module ufp_result_checker
    import ufp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    ufp_in_if    i_req,
    ufp_out_if   i_res,
    output int   o_errors,
    output int   o_pending
);

    typedef struct packed {
        logic [7:0] out_byte;
        t_role      role;
        logic       has_value;
        logic       run_last;
    } t_form_result;

    // parser state as seen from outside
    t_seg       cur_seg;
    t_esc       cur_esc;
    logic [7:0] held_char;

    t_form_result burst_results[$];
    t_form_result expected_results[$];
    int           mismatches = 0;

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        return -1;
    endfunction

    function automatic void push_result(input logic [7:0] b, input t_role r, input logic hv);
        t_form_result e;
        if (burst_results.size() >= N_RES) return;
        e.out_byte  = b;
        e.role      = r;
        e.has_value = hv;
        e.run_last  = 1'b0;
        burst_results.push_back(e);
    endfunction

    function automatic void emit_data(input logic [7:0] b);
        push_result(b, (cur_seg == SEG_NAME) ? ROLE_NAME : ROLE_VALUE, 1'b0);
    endfunction

    // unfinished escape goes out as literal bytes
    function automatic void flush_escape();
        if (cur_esc == ESC_PCT) begin
            emit_data(C_PCT);
        end else if (cur_esc == ESC_DIGIT) begin
            emit_data(C_PCT);
            emit_data(held_char);
        end
        cur_esc = ESC_NONE;
    endfunction

    function automatic void close_pair();
        push_result(8'h00, ROLE_PAIR_END, cur_seg != SEG_NAME);
        cur_seg = SEG_NAME;
        cur_esc = ESC_NONE;
    endfunction

    function automatic void take_plain(input logic [7:0] b);
        if (b == C_PCT) begin
            cur_esc = ESC_PCT;
        end else begin
            emit_data(b);
        end
    endfunction

    function automatic void take_byte(input logic [7:0] b);
        int nib;
        if (cur_seg == SEG_DROP) begin
            cur_esc = ESC_NONE;
            if (b == C_AMP) close_pair();
            return;
        end
        if (b == C_AMP || b == C_EQ) begin
            flush_escape();
            if (b == C_AMP) begin
                close_pair();
            end else begin
                cur_seg = (cur_seg == SEG_NAME) ? SEG_VALUE : SEG_DROP;
            end
            return;
        end
        nib = nibble_of(b);
        case (cur_esc)
            ESC_PCT: begin
                if (nib >= 0) begin
                    held_char = b;
                    cur_esc   = ESC_DIGIT;
                end else begin
                    emit_data(C_PCT);
                    cur_esc = ESC_NONE;
                    take_plain(b);
                end
            end
            ESC_DIGIT: begin
                if (nib >= 0) begin
                    emit_data({4'(nibble_of(held_char)), 4'(nib)});
                    cur_esc = ESC_NONE;
                end else begin
                    // failing byte is handled afresh and may open a new escape
                    emit_data(C_PCT);
                    emit_data(held_char);
                    cur_esc = ESC_NONE;
                    take_plain(b);
                end
            end
            default: take_plain(b);
        endcase
    endfunction

    function automatic void decode_request(input logic [7:0] b, input logic last);
        t_form_result tail;
        burst_results.delete();
        take_byte(b);
        if (last) begin
            if (cur_seg != SEG_DROP) flush_escape();
            close_pair();
            held_char = 8'h00;
        end
        if (burst_results.size() > 0) begin
            tail = burst_results.pop_back();
            tail.run_last = 1'b1;
            burst_results.push_back(tail);
        end
        foreach (burst_results[k]) expected_results.push_back(burst_results[k]);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_result();
        t_form_result got;
        t_form_result want;
        got.out_byte  = i_res.out_byte;
        got.role      = t_role'(i_res.role);
        got.has_value = i_res.has_value;
        got.run_last  = i_res.run_last;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result %02h role %0d with nothing outstanding",
                                      got.out_byte, got.role));
            return;
        end
        want = expected_results.pop_front();
        if (got.out_byte !== want.out_byte || got.role !== want.role ||
            got.has_value !== want.has_value || got.run_last !== want.run_last) begin
            report_mismatch($sformatf(
                "byte/role/has_value/run_last got %02h/%0d/%0d/%0d want %02h/%0d/%0d/%0d",
                got.out_byte, got.role, got.has_value, got.run_last,
                want.out_byte, want.role, want.has_value, want.run_last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_seg   = SEG_NAME;
            cur_esc   = ESC_NONE;
            held_char = 8'h00;
            expected_results.delete();
        end else begin
            if (i_req.valid && i_req.ready) decode_request(i_req.in_byte, i_req.body_last);
            if (i_res.valid && i_res.ready) check_result();
        end
        o_pending <= expected_results.size();
        o_errors  <= mismatches;
    end

endmodule

// ----- dv/urlencoded_form_parser_top_test.sv -----
// Testbench top for the form parser: clock, reset, byte stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module urlencoded_form_parser_top_test;
    import ufp_pkg::*;

    localparam int BYTES_PER_PHASE = 112;
    localparam int WATCHDOG_LIMIT  = 2000;

    logic i_clk;
    logic i_rst_n;

    ufp_in_if  in_ch ();
    ufp_out_if out_ch ();

    int chk_errors;
    int chk_pending;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;

    // idle percentages per phase: none, sender, receiver, both
    int send_plan[4]  = '{0, 71, 0, 24};
    int stall_plan[4] = '{0, 0, 71, 24};

    logic [7:0] body_q[$];

    urlencoded_form_parser_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    ufp_result_checker i_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (in_ch),
        .i_res     (out_ch),
        .o_errors  (chk_errors),
        .o_pending (chk_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [7:0] pick_hex_char();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(21)];
    endfunction

    function automatic logic [7:0] pick_nonhex();
        logic [7:0] b;
        do b = 8'($urandom_range(255));
        while ((b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f"));
        return b;
    endfunction

    function automatic logic [7:0] pick_plain();
        string common;
        logic [7:0] b;
        common = "abzAZ09_-.~*!";
        if ($urandom_range(99) < 70) return common[$urandom_range(common.len() - 1)];
        do b = 8'($urandom_range(255));
        while (b == C_AMP || b == C_EQ || b == C_PCT);
        return b;
    endfunction

    function automatic void add_text(input string s);
        for (int k = 0; k < s.len(); k++) body_q.push_back(s[k]);
    endfunction

    // name or value text: plain bytes, good and bad escapes, a little noise
    function automatic void add_segment();
        int kind;
        repeat ($urandom_range(5)) begin
            kind = $urandom_range(99);
            if (kind < 50) begin
                body_q.push_back(pick_plain());
            end else if (kind < 72) begin
                body_q.push_back(C_PCT);
                body_q.push_back(pick_hex_char());
                body_q.push_back(pick_hex_char());
            end else if (kind < 80) begin
                body_q.push_back(C_PCT);
                body_q.push_back(pick_nonhex());
            end else if (kind < 87) begin
                body_q.push_back(C_PCT);
                body_q.push_back(pick_hex_char());
                body_q.push_back(pick_nonhex());
            end else if (kind < 92) begin
                body_q.push_back("+");
            end else if (kind < 97) begin
                body_q.push_back(8'($urandom_range(255)));
            end else begin
                body_q.push_back(C_PCT);
            end
        end
    endfunction

    function automatic void build_body();
        int pairs;
        body_q.delete();
        if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(1, 8)) body_q.push_back(8'($urandom_range(255)));
            return;
        end
        pairs = $urandom_range(1, 4);
        for (int p = 0; p < pairs; p++) begin
            if (p > 0) body_q.push_back(C_AMP);
            add_segment();
            if ($urandom_range(99) < 80) begin
                body_q.push_back(C_EQ);
                add_segment();
                if ($urandom_range(99) < 12) begin
                    body_q.push_back(C_EQ);
                    add_segment();
                end
            end
        end
        if ($urandom_range(99) < 10) body_q.push_back(C_AMP);
        if (body_q.size() == 0) body_q.push_back(pick_plain());
    endfunction

    task automatic send_body();
        for (int i = 0; i < body_q.size(); i++) begin
            while ($urandom_range(99) < send_idle_pct) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
            in_ch.valid     <= 1'b1;
            in_ch.in_byte   <= body_q[i];
            in_ch.body_last <= (i == body_q.size() - 1);
            do @(posedge i_clk); while (!in_ch.ready);
        end
        items_sent += body_q.size();
    endtask

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int phase_start;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.in_byte   <= 8'h00;
        in_ch.body_last <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, both hex cases, '+', trailing ampersand
        body_q.delete();
        body_q.push_back(8'h00);
        add_text("%4A=%6a+");
        body_q.push_back(8'hFF);
        add_text("&");
        send_body();
        // bad first digit, bad second digit opening a new escape, escape cut by end of body
        body_q.delete();
        add_text("%g%4%41%5");
        send_body();
        // escapes cut by '=', dropped tail with '%', closed by '&', then an empty pair
        body_q.delete();
        add_text("%=%7=%&");
        send_body();

        for (int ph = 0; ph < 4; ph++) begin
            // hold off until the parser has drained everything
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while (chk_pending != 0);
            send_idle_pct  = send_plan[ph];
            recv_stall_pct = stall_plan[ph];
            phase_start    = items_sent;
            while (items_sent - phase_start < BYTES_PER_PHASE) begin
                build_body();
                send_body();
            end
        end

        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (chk_pending != 0);
        repeat (8) @(posedge i_clk);
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
